// ===== hdl/maf_pkg.sv =====
// maf_pkg: shared types and default constants for the moving average filter
// no dependencies; used by moving_average_filter
package maf_pkg;

  // default window length and sample width
  localparam int MAF_WINDOW      = 8;
  localparam int MAF_SAMPLE_BITS = 16;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_ABS,
    ST_DIV,
    ST_NEG,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/moving_average_filter.sv =====
// moving_average_filter: boxcar average over the last WINDOW samples
// depends on maf_pkg (state type, default constants)
//
//  channel | dir | tdata (low bit up)  | tuser        | tlast
//  --------+-----+---------------------+--------------+------
//  s_*     | in  | sample              | -            | -
//  m_*     | out | average             | window_full  | -
//
// Each sample runs through the sequencer steps in order: take the input transfer
// and read the ring, update the running sum (subtract the overwritten entry,
// then add the new sample), take the magnitude, run the restoring division by
// the fill count, fix the sign and load the output register. A new input
// transfer is taken only once the sequencer is back in idle; all of it runs
// through one shared adder under the sequencer.
// s_tready is high only while the sequencer is idle. A finished result sits in
// the output register while the next sample is taken in; a stalled output
// holds the sequencer in its last step. Synchronous reset clears sum, position
// and fill count; ring entries not yet written read as zero through the fill
// count, so no clearing pass is needed.
module moving_average_filter #(
  parameter int WINDOW      = maf_pkg::MAF_WINDOW,
  parameter int SAMPLE_BITS = maf_pkg::MAF_SAMPLE_BITS,
  localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // input samples
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_BITS-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample
  // averages
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_BITS-1:0] m_tdata,   // [SAMPLE_BITS-1:0] average
  output logic                 m_tuser    // [0] window_full
);

  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int POS_BITS   = $clog2(WINDOW);
  localparam int COUNT_BITS = $clog2(WINDOW + 1);
  localparam int ITER_BITS  = $clog2(SUM_BITS);

  maf_pkg::state_t state, state_next;

  logic [SAMPLE_BITS-1:0] ring [WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] samp;

  logic [POS_BITS-1:0]    pos, pos_next;
  logic [COUNT_BITS-1:0]  fill, fill_next;
  logic [SUM_BITS-1:0]    sum, sum_next;
  logic [SUM_BITS-1:0]    quo, quo_next;
  logic [COUNT_BITS-1:0]  rem, rem_next;
  logic [ITER_BITS-1:0]   iter, iter_next;
  logic                   neg, neg_next;
  logic                   full;
  logic                   ring_we;
  logic                   out_load;

  logic [SAMPLE_BITS-1:0] avg_q;
  logic                   full_q;

  // shared adder / subtractor
  logic [SUM_BITS-1:0]    alu_a, alu_b;
  logic                   alu_sub;
  logic [SUM_BITS:0]      alu_y;
  logic [COUNT_BITS:0]    rem_shift;

  assign full     = (fill == COUNT_BITS'(WINDOW));
  assign s_tready = (state == maf_pkg::ST_IDLE);
  assign alu_y    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                    + {{SUM_BITS{1'b0}}, alu_sub};
  assign rem_shift = {rem, quo[SUM_BITS-1]};

  // sequencer and datapath next values
  always_comb begin
    state_next = state;
    pos_next   = pos;
    fill_next  = fill;
    sum_next   = sum;
    quo_next   = quo;
    rem_next   = rem;
    iter_next  = iter;
    neg_next   = neg;
    ring_we    = 1'b0;
    out_load   = 1'b0;
    alu_a      = sum;
    alu_b      = '0;
    alu_sub    = 1'b0;
    case (state)
      maf_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = maf_pkg::ST_SUB;
        end
      end
      maf_pkg::ST_SUB: begin
        // remove the entry being overwritten (zero while still filling)
        alu_a      = sum;
        alu_b      = full ? SUM_BITS'($signed(rd_data)) : '0;
        alu_sub    = 1'b1;
        sum_next   = alu_y[SUM_BITS-1:0];
        state_next = maf_pkg::ST_ADD;
      end
      maf_pkg::ST_ADD: begin
        // add the new sample, store it, advance position and fill count
        alu_a      = sum;
        alu_b      = SUM_BITS'($signed(samp));
        sum_next   = alu_y[SUM_BITS-1:0];
        ring_we    = 1'b1;
        pos_next   = (pos == POS_BITS'(WINDOW - 1)) ? '0 : pos + 1'b1;
        fill_next  = full ? fill : fill + 1'b1;
        state_next = maf_pkg::ST_ABS;
      end
      maf_pkg::ST_ABS: begin
        // magnitude of the sum becomes the dividend
        alu_a      = '0;
        alu_b      = sum;
        alu_sub    = 1'b1;
        neg_next   = sum[SUM_BITS-1];
        quo_next   = sum[SUM_BITS-1] ? alu_y[SUM_BITS-1:0] : sum;
        rem_next   = '0;
        iter_next  = '0;
        state_next = maf_pkg::ST_DIV;
      end
      maf_pkg::ST_DIV: begin
        // one restoring division step per cycle
        alu_a     = SUM_BITS'(rem_shift);
        alu_b     = SUM_BITS'(fill);
        alu_sub   = 1'b1;
        rem_next  = alu_y[SUM_BITS] ? alu_y[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
        quo_next  = {quo[SUM_BITS-2:0], alu_y[SUM_BITS]};
        iter_next = iter + 1'b1;
        if (iter == ITER_BITS'(SUM_BITS - 1)) begin
          state_next = maf_pkg::ST_NEG;
        end
      end
      maf_pkg::ST_NEG: begin
        // restore the sign, truncation toward zero
        alu_a      = '0;
        alu_b      = quo;
        alu_sub    = 1'b1;
        quo_next   = neg ? alu_y[SUM_BITS-1:0] : quo;
        state_next = maf_pkg::ST_DONE;
      end
      maf_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = maf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = maf_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= maf_pkg::ST_IDLE;
      pos      <= '0;
      fill     <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      fill  <= fill_next;
      sum   <= sum_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    quo  <= quo_next;
    rem  <= rem_next;
    iter <= iter_next;
    neg  <= neg_next;
    if (s_tvalid && s_tready) begin
      samp <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (out_load) begin
      avg_q  <= quo[SAMPLE_BITS-1:0];
      full_q <= full;
    end
  end

  // sample ring: read on the input transfer, written in the add step
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rd_data <= ring[pos];
    end
    if (ring_we) begin
      ring[pos] <= samp;
    end
  end

  assign m_tdata = DATA_BITS'(avg_q);
  assign m_tuser = full_q;

endmodule
